// ===== sv/lsc_pkg.sv =====
// Shared types, widths and helpers for the line segment window clipper.
package lsc_pkg;

  localparam int COORD_BITS    = 16;
  localparam int FRACTION_BITS = 16;
  localparam int NUM_TESTS     = 4;

  // Differences of two coordinates need one more bit; their magnitudes fit COORD_BITS.
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int MAG_W  = COORD_BITS;
  // Quotient holds the integer bit plus FRACTION_BITS fraction bits.
  localparam int QUO_W  = FRACTION_BITS + 1;
  // Signed ratio wide enough for -1 and for one above 1.0.
  localparam int RAT_W  = FRACTION_BITS + 3;
  localparam int PROD_W = MAG_W + QUO_W;

  localparam logic [2:0] CFG_LEFT   = 3'd0;
  localparam logic [2:0] CFG_BOTTOM = 3'd1;
  localparam logic [2:0] CFG_RIGHT  = 3'd2;
  localparam logic [2:0] CFG_TOP    = 3'd3;

  // How the ratio of one boundary test is settled.
  typedef enum logic [5:0] {
    R_ZERO    = 6'b000001,
    R_NEG     = 6'b000010,
    R_OVER    = 6'b000100,
    R_DIV     = 6'b001000,
    R_PAR_OK  = 6'b010000,
    R_PAR_REJ = 6'b100000
  } ratio_kind_t;

  typedef struct packed {
    ratio_kind_t        kind;
    logic               p_neg;
    logic [MAG_W-1:0]   den;
    logic [MAG_W-1:0]   rem;
    logic [QUO_W-1:0]   quo;
  } lane_t;

  typedef struct packed {
    logic                         valid;
    logic signed [COORD_BITS-1:0] sx;
    logic signed [COORD_BITS-1:0] sy;
    logic signed [DIFF_W-1:0]     dx;
    logic signed [DIFF_W-1:0]     dy;
    lane_t [NUM_TESTS-1:0]        lane;
  } item_t;

  function automatic logic [MAG_W-1:0] mag(input logic signed [DIFF_W-1:0] v);
    logic [DIFF_W-1:0] a;
    a = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
    return a[MAG_W-1:0];
  endfunction

endpackage

// ===== sv/line_segment_window_clipper_top.sv =====
// Top level of the Liang-Barsky line segment window clipper.
//
//   Channel   Direction  Handshake           Fields
//   request   in         start, busy         start_x, start_y, end_x, end_y
//   result    out        done (one cycle)    visible, clipped_start_x/y, clipped_end_x/y
//   config    in         cfg_we              cfg_index, cfg_data
//
// A request is taken at every clock edge with start high and busy low, so one segment
// can enter in every cycle. Each result passes through the front stage, the divider
// chain, one cell per fraction bit, and the four back-end stages.
// Reset is synchronous: it clears the pipeline valid bits and loads the window
// registers with their reset values; busy is high only while reset is held.
// The receiver cannot stall, so results leave on the cycle they reach the end.
module line_segment_window_clipper_top import lsc_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [COORD_BITS-1:0]        cfg_data,
  output logic                         done,
  output logic                         visible,
  output logic signed [COORD_BITS-1:0] clipped_start_x,
  output logic signed [COORD_BITS-1:0] clipped_start_y,
  output logic signed [COORD_BITS-1:0] clipped_end_x,
  output logic signed [COORD_BITS-1:0] clipped_end_y
);

  localparam int LATENCY = FRACTION_BITS + 5;

  logic signed [COORD_BITS-1:0] win_left, win_bottom, win_right, win_top;
  logic                         accept;

  // The chain of divider cells; entry 0 is fed by the front stage.
  item_t chain [FRACTION_BITS+1];

  assign busy   = rst;
  assign accept = start && !busy;

  // Window registers. Writes to an index past the top register are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      win_left   <= COORD_BITS'(50);
      win_bottom <= COORD_BITS'(50);
      win_right  <= COORD_BITS'(400);
      win_top    <= COORD_BITS'(400);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LEFT:   win_left   <= cfg_data;
        CFG_BOTTOM: win_bottom <= cfg_data;
        CFG_RIGHT:  win_right  <= cfg_data;
        CFG_TOP:    win_top    <= cfg_data;
        default:    ;
      endcase
    end
  end

  lsc_prep u_prep (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (accept),
    .sx         (start_x),
    .sy         (start_y),
    .ex         (end_x),
    .ey         (end_y),
    .win_left   (win_left),
    .win_bottom (win_bottom),
    .win_right  (win_right),
    .win_top    (win_top),
    .item       (chain[0])
  );

  // Each cell settles one fraction bit of all four ratios and passes the segment on.
  for (genvar k = 0; k < FRACTION_BITS; k++) begin : g_cell
    lsc_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .item_in  (chain[k]),
      .item_out (chain[k+1])
    );
  end

  lsc_place u_place (
    .clk             (clk),
    .rst             (rst),
    .item            (chain[FRACTION_BITS]),
    .done            (done),
    .visible         (visible),
    .clipped_start_x (clipped_start_x),
    .clipped_start_y (clipped_start_y),
    .clipped_end_x   (clipped_end_x),
    .clipped_end_y   (clipped_end_y)
  );

  // Every result comes from a request taken a fixed number of cycles earlier.
  a_done_has_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result without a matching request");

  // Every request produces its result after the pipeline latency.
  a_request_gives_done: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("request lost in the pipeline");

  // A rejected segment reports all clipped coordinates as zero.
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !visible) |-> (clipped_start_x == '0 && clipped_start_y == '0 &&
                            clipped_end_x == '0 && clipped_end_y == '0))
    else $error("rejected segment with nonzero coordinates");

endmodule

// ===== sv/lsc_prep.sv =====
// Front stage: forms the boundary terms and the first quotient step of each test.
module lsc_prep import lsc_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic signed [COORD_BITS-1:0] sx,
  input  logic signed [COORD_BITS-1:0] sy,
  input  logic signed [COORD_BITS-1:0] ex,
  input  logic signed [COORD_BITS-1:0] ey,
  input  logic signed [COORD_BITS-1:0] win_left,
  input  logic signed [COORD_BITS-1:0] win_bottom,
  input  logic signed [COORD_BITS-1:0] win_right,
  input  logic signed [COORD_BITS-1:0] win_top,
  output item_t                        item
);

  item_t                    item_next;
  logic signed [DIFF_W-1:0] dx, dy;
  logic signed [DIFF_W-1:0] p [NUM_TESTS];
  logic signed [DIFF_W-1:0] q [NUM_TESTS];
  logic [MAG_W-1:0]         ap, aq;

  always_comb begin
    dx = DIFF_W'(ex) - DIFF_W'(sx);
    dy = DIFF_W'(ey) - DIFF_W'(sy);
    p[0] = -dx;  q[0] = DIFF_W'(sx) - DIFF_W'(win_left);
    p[1] = dx;   q[1] = DIFF_W'(win_right) - DIFF_W'(sx);
    p[2] = -dy;  q[2] = DIFF_W'(sy) - DIFF_W'(win_bottom);
    p[3] = dy;   q[3] = DIFF_W'(win_top) - DIFF_W'(sy);
    // Reset clears the valid bit on its way into the register.
    item_next.valid = in_valid && !rst;
    item_next.sx = sx;
    item_next.sy = sy;
    item_next.dx = dx;
    item_next.dy = dy;
    ap = '0;
    aq = '0;
    for (int i = 0; i < NUM_TESTS; i++) begin
      ap = mag(p[i]);
      aq = mag(q[i]);
      item_next.lane[i].p_neg = p[i][DIFF_W-1];
      item_next.lane[i].den   = ap;
      if (p[i] == '0) begin
        item_next.lane[i].kind = q[i][DIFF_W-1] ? R_PAR_REJ : R_PAR_OK;
      end else if (q[i] == '0) begin
        item_next.lane[i].kind = R_ZERO;
      end else if (p[i][DIFF_W-1] != q[i][DIFF_W-1]) begin
        item_next.lane[i].kind = R_NEG;
      end else if (aq > ap) begin
        item_next.lane[i].kind = R_OVER;
      end else begin
        item_next.lane[i].kind = R_DIV;
      end
      // Integer bit of the quotient; it is set whenever |q| is at least |p|.
      if (aq >= ap) begin
        item_next.lane[i].quo = QUO_W'(1);
        item_next.lane[i].rem = aq - ap;
      end else begin
        item_next.lane[i].quo = '0;
        item_next.lane[i].rem = aq;
      end
    end
  end

  always_ff @(posedge clk) begin
    item <= item_next;
  end

endmodule

// ===== sv/lsc_div_cell.sv =====
// One cell of the divider chain: one quotient bit for each of the four tests.
module lsc_div_cell import lsc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  item_t item_in,
  output item_t item_out
);

  item_t            item_next;
  logic [MAG_W:0]   shifted;
  logic [MAG_W:0]   diff;

  always_comb begin
    item_next = item_in;
    item_next.valid = item_in.valid && !rst;
    shifted = '0;
    diff = '0;
    for (int i = 0; i < NUM_TESTS; i++) begin
      shifted = {item_in.lane[i].rem, 1'b0};
      diff = shifted - {1'b0, item_in.lane[i].den};
      if (shifted >= {1'b0, item_in.lane[i].den}) begin
        item_next.lane[i].rem = diff[MAG_W-1:0];
        item_next.lane[i].quo = {item_in.lane[i].quo[QUO_W-2:0], 1'b1};
      end else begin
        item_next.lane[i].rem = shifted[MAG_W-1:0];
        item_next.lane[i].quo = {item_in.lane[i].quo[QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    item_out <= item_next;
  end

endmodule

// ===== sv/lsc_place.sv =====
// Back end: rounds the ratios, runs the four tests and places the clipped endpoints.
module lsc_place import lsc_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  item_t                        item,
  output logic                         done,
  output logic                         visible,
  output logic signed [COORD_BITS-1:0] clipped_start_x,
  output logic signed [COORD_BITS-1:0] clipped_start_y,
  output logic signed [COORD_BITS-1:0] clipped_end_x,
  output logic signed [COORD_BITS-1:0] clipped_end_y
);

  localparam logic signed [RAT_W-1:0] ONE_FX = RAT_W'(1) <<< FRACTION_BITS;
  localparam logic [PROD_W:0]         HALF   = (PROD_W+1)'(1) << (FRACTION_BITS - 1);

  // Stage 1: rounded ratios.
  logic                         s1_valid;
  logic signed [RAT_W-1:0]      s1_r [NUM_TESTS];
  ratio_kind_t                  s1_kind [NUM_TESTS];
  logic                         s1_pneg [NUM_TESTS];
  logic signed [COORD_BITS-1:0] s1_sx, s1_sy;
  logic signed [DIFF_W-1:0]     s1_dx, s1_dy;
  logic signed [RAT_W-1:0]      r_next [NUM_TESTS];
  logic [MAG_W:0]               twice_rem;

  always_comb begin
    twice_rem = '0;
    for (int i = 0; i < NUM_TESTS; i++) begin
      twice_rem = {item.lane[i].rem, 1'b0};
      case (item.lane[i].kind)
        R_NEG:   r_next[i] = '1;
        R_OVER:  r_next[i] = ONE_FX + RAT_W'(1);
        R_DIV:   r_next[i] = RAT_W'(item.lane[i].quo)
                   + RAT_W'(twice_rem >= {1'b0, item.lane[i].den});
        default: r_next[i] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_TESTS; i++) begin
      s1_r[i]    <= r_next[i];
      s1_kind[i] <= item.lane[i].kind;
      s1_pneg[i] <= item.lane[i].p_neg;
    end
    s1_sx <= item.sx;
    s1_sy <= item.sy;
    s1_dx <= item.dx;
    s1_dy <= item.dy;
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= item.valid;
    end
  end

  // Stage 2: the four boundary tests in order left, right, bottom, top.
  logic                         s2_valid, s2_ok;
  logic [QUO_W-1:0]             s2_u1, s2_u2;
  logic                         s2_xneg, s2_yneg;
  logic [MAG_W-1:0]             s2_ax, s2_ay;
  logic signed [COORD_BITS-1:0] s2_sx, s2_sy;
  logic                         ok_next;
  logic signed [RAT_W-1:0]      u1, u2;

  always_comb begin
    ok_next = 1'b1;
    u1 = '0;
    u2 = ONE_FX;
    for (int i = 0; i < NUM_TESTS; i++) begin
      if (s1_kind[i] == R_PAR_REJ) begin
        ok_next = 1'b0;
      end else if (s1_kind[i] == R_PAR_OK) begin
        ok_next = ok_next;
      end else if (s1_pneg[i]) begin
        if (s1_r[i] > u2) begin
          ok_next = 1'b0;
        end else if (s1_r[i] > u1) begin
          u1 = s1_r[i];
        end
      end else begin
        if (s1_r[i] < u1) begin
          ok_next = 1'b0;
        end else if (s1_r[i] < u2) begin
          u2 = s1_r[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_ok   <= ok_next;
    s2_u1   <= u1[QUO_W-1:0];
    s2_u2   <= u2[QUO_W-1:0];
    s2_xneg <= s1_dx[DIFF_W-1];
    s2_yneg <= s1_dy[DIFF_W-1];
    s2_ax   <= mag(s1_dx);
    s2_ay   <= mag(s1_dy);
    s2_sx   <= s1_sx;
    s2_sy   <= s1_sy;
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  // Stage 3: the four products of delta and parameter.
  logic                         s3_valid, s3_ok, s3_xneg, s3_yneg;
  logic [PROD_W-1:0]            s3_px1, s3_py1, s3_px2, s3_py2;
  logic signed [COORD_BITS-1:0] s3_sx, s3_sy;

  always_ff @(posedge clk) begin
    s3_px1  <= PROD_W'(s2_ax) * PROD_W'(s2_u1);
    s3_py1  <= PROD_W'(s2_ay) * PROD_W'(s2_u1);
    s3_px2  <= PROD_W'(s2_ax) * PROD_W'(s2_u2);
    s3_py2  <= PROD_W'(s2_ay) * PROD_W'(s2_u2);
    s3_ok   <= s2_ok;
    s3_xneg <= s2_xneg;
    s3_yneg <= s2_yneg;
    s3_sx   <= s2_sx;
    s3_sy   <= s2_sy;
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  // Stage 4: round each product and step away from the start point.
  function automatic logic [COORD_BITS-1:0] place(
    input logic [COORD_BITS-1:0] s,
    input logic                  neg,
    input logic [PROD_W-1:0]     prod
  );
    logic [PROD_W:0]     rounded;
    logic [MAG_W-1:0]    m;
    rounded = {1'b0, prod} + HALF;
    m = rounded[FRACTION_BITS +: MAG_W];
    return neg ? COORD_BITS'(s - m) : COORD_BITS'(s + m);
  endfunction

  always_ff @(posedge clk) begin
    visible         <= s3_ok;
    clipped_start_x <= s3_ok ? place(s3_sx, s3_xneg, s3_px1) : '0;
    clipped_start_y <= s3_ok ? place(s3_sy, s3_yneg, s3_py1) : '0;
    clipped_end_x   <= s3_ok ? place(s3_sx, s3_xneg, s3_px2) : '0;
    clipped_end_y   <= s3_ok ? place(s3_sy, s3_yneg, s3_py2) : '0;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s3_valid;
    end
  end

endmodule
